// File: rtl/vdm_pkg.sv
package vdm_pkg;

    // Widths of the fields on the ports.
    localparam int unsigned ELEM_W      = 16;
    localparam int unsigned ABS_W       = 26;
    localparam int unsigned SQ_W        = 42;
    localparam int unsigned ROOT_W      = 21;
    localparam int unsigned DIFF_W      = 16;
    localparam int unsigned PROD_W      = 2 * DIFF_W;
    localparam int unsigned S_TDATA_W   = 32;
    localparam int unsigned M_TDATA_W   = 64;

    // Square root unit: one result bit per step, two operand bits per step.
    localparam int unsigned SQRT_STEPS  = SQ_W / 2;
    localparam int unsigned REM_W       = ROOT_W + 1;
    localparam int unsigned STEP_CNT_W  = $clog2(SQRT_STEPS);

    typedef enum logic [1:0] {
        S_ACCUM,
        S_FINAL,
        S_ROOT,
        S_HOLD
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start_root;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic root_done;
        logic out_free;
    } t_sts;

endpackage

// File: rtl/vdm_sqrt.sv
module vdm_sqrt
    import vdm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SQ_W-1:0]   i_radicand,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    logic [SQ_W-1:0]       r_rad,   n_rad;
    logic [REM_W-1:0]      r_rem,   n_rem;
    logic [ROOT_W-1:0]     r_root,  n_root;
    logic [STEP_CNT_W-1:0] r_count, n_count;
    logic                  r_busy,  n_busy;
    logic                  r_done,  n_done;

    logic [REM_W+1:0]      rem_sh;
    logic [REM_W+1:0]      trial;

    // Restoring digit recurrence: bring down two radicand bits, try root*4+1.
    always_comb begin
        rem_sh  = {r_rem, r_rad[SQ_W-1 -: 2]};
        trial   = {1'b0, r_root, 2'b01};
        n_rad   = r_rad;
        n_rem   = r_rem;
        n_root  = r_root;
        n_count = r_count;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_rad   = i_radicand;
            n_rem   = '0;
            n_root  = '0;
            n_count = STEP_CNT_W'(SQRT_STEPS - 1);
            n_busy  = 1'b1;
        end else if (r_busy) begin
            n_rad = {r_rad[SQ_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                n_rem  = REM_W'(rem_sh - trial);
                n_root = {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = rem_sh[REM_W-1:0];
                n_root = {r_root[ROOT_W-2:0], 1'b0};
            end
            if (r_count == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_count = r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rad   <= n_rad;
        r_rem   <= n_rem;
        r_root  <= n_root;
        r_count <= n_count;
    end

    assign o_done = r_done;
    assign o_root = r_root;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("square root did not start");

    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("square root done while still busy");

endmodule

// File: rtl/vdm_datapath.sv
module vdm_datapath
    import vdm_pkg::*;
#(
    parameter int unsigned MAX_LENGTH = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [ELEM_W-1:0] i_first_value,
    input  logic [ELEM_W-1:0] i_second_value,
    input  logic              i_last_element,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [ABS_W-1:0]  o_manhattan_distance,
    output logic [ROOT_W-1:0] o_euclidean_distance,
    output logic [DIFF_W-1:0] o_chebyshev_distance,
    output logic              o_saturated
);

    localparam int unsigned CNT_W = $clog2(MAX_LENGTH + 1);
    localparam logic [63:0] ABS_LIM   = 64'(MAX_LENGTH) * 64'd65535;
    localparam logic [63:0] SQ_LIM    = 64'(MAX_LENGTH) * 64'd65535 * 64'd65535;
    localparam logic [63:0] ABS_FULL  = (64'd1 << ABS_W) - 64'd1;
    localparam logic [63:0] SQ_FULL   = (64'd1 << SQ_W) - 64'd1;
    localparam logic [63:0] ABS_CAP64 = (ABS_LIM < ABS_FULL) ? ABS_LIM : ABS_FULL;
    localparam logic [63:0] SQ_CAP64  = (SQ_LIM < SQ_FULL) ? SQ_LIM : SQ_FULL;
    localparam logic [ABS_W-1:0] ABS_CAP = ABS_CAP64[ABS_W-1:0];
    localparam logic [SQ_W-1:0]  SQ_CAP  = SQ_CAP64[SQ_W-1:0];
    localparam logic [CNT_W-1:0] LEN_MAX = CNT_W'(MAX_LENGTH);

    // Stage one: difference, magnitude and square.
    logic signed [ELEM_W:0] diff;
    logic [ELEM_W:0]        diff_mag;
    logic [DIFF_W-1:0]      abs_diff;
    logic [PROD_W-1:0]      square;

    logic                   r_s1_valid;
    logic                   r_s1_last;
    logic [DIFF_W-1:0]      r_s1_abs;
    logic [PROD_W-1:0]      r_s1_sq;

    always_comb begin
        diff     = $signed({i_first_value[ELEM_W-1], i_first_value})
                 - $signed({i_second_value[ELEM_W-1], i_second_value});
        diff_mag = diff[ELEM_W] ? (ELEM_W+1)'(-diff) : diff;
        abs_diff = diff_mag[DIFF_W-1:0];
        square   = abs_diff * abs_diff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_accept;
        end
        if (i_accept) begin
            r_s1_last <= i_last_element;
            r_s1_abs  <= abs_diff;
            r_s1_sq   <= square;
        end
    end

    // Stage two: saturating accumulators.
    logic [ABS_W-1:0]  r_abs_sum, n_abs_sum;
    logic [SQ_W-1:0]   r_sq_sum,  n_sq_sum;
    logic [DIFF_W-1:0] r_max,     n_max;
    logic [CNT_W-1:0]  r_count,   n_count;
    logic              r_ovf,     n_ovf;
    logic [ABS_W:0]    abs_add;
    logic [SQ_W:0]     sq_add;
    logic              vec_end;

    always_comb begin
        abs_add   = {1'b0, r_abs_sum} + (ABS_W+1)'(r_s1_abs);
        sq_add    = {1'b0, r_sq_sum} + (SQ_W+1)'(r_s1_sq);
        n_abs_sum = r_abs_sum;
        n_sq_sum  = r_sq_sum;
        n_max     = r_max;
        n_count   = r_count;
        n_ovf     = r_ovf;
        if (r_s1_valid) begin
            if (r_count >= LEN_MAX) begin
                n_ovf = 1'b1;
            end else begin
                n_count = r_count + 1'b1;
            end
            if (r_abs_sum >= ABS_CAP || abs_add > {1'b0, ABS_CAP}) begin
                n_abs_sum = ABS_CAP;
                n_ovf     = 1'b1;
            end else begin
                n_abs_sum = abs_add[ABS_W-1:0];
            end
            if (r_sq_sum >= SQ_CAP || sq_add > {1'b0, SQ_CAP}) begin
                n_sq_sum = SQ_CAP;
                n_ovf    = 1'b1;
            end else begin
                n_sq_sum = sq_add[SQ_W-1:0];
            end
            if (r_s1_abs > r_max) begin
                n_max = r_s1_abs;
            end
        end
    end

    assign vec_end = r_s1_valid && r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || vec_end) begin
            r_abs_sum <= '0;
            r_sq_sum  <= '0;
            r_max     <= '0;
            r_count   <= '0;
            r_ovf     <= 1'b0;
        end else begin
            r_abs_sum <= n_abs_sum;
            r_sq_sum  <= n_sq_sum;
            r_max     <= n_max;
            r_count   <= n_count;
            r_ovf     <= n_ovf;
        end
    end

    // Final sums of a vector wait here while the root is worked out.
    logic [ABS_W-1:0]  r_res_abs;
    logic [DIFF_W-1:0] r_res_max;
    logic              r_res_ovf;
    logic              root_done;
    logic [ROOT_W-1:0] root;

    always_ff @(posedge i_clk) begin
        if (vec_end) begin
            r_res_abs <= n_abs_sum;
            r_res_max <= n_max;
            r_res_ovf <= n_ovf;
        end
    end

    vdm_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start_root),
        .i_radicand (n_sq_sum),
        .o_done     (root_done),
        .o_root     (root)
    );

    // Output register.
    logic              r_out_valid;
    logic [ABS_W-1:0]  r_out_abs;
    logic [ROOT_W-1:0] r_out_root;
    logic [DIFF_W-1:0] r_out_max;
    logic              r_out_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.load_out) begin
            r_out_abs  <= r_res_abs;
            r_out_root <= root;
            r_out_max  <= r_res_max;
            r_out_ovf  <= r_res_ovf;
        end
    end

    assign o_sts.root_done     = root_done;
    assign o_sts.out_free      = !r_out_valid || i_out_ready;
    assign o_out_valid          = r_out_valid;
    assign o_manhattan_distance = r_out_abs;
    assign o_euclidean_distance = r_out_root;
    assign o_chebyshev_distance = r_out_max;
    assign o_saturated          = r_out_ovf;

    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        vec_end |=> (r_abs_sum == '0 && r_sq_sum == '0 && r_count == '0 && !r_ovf))
        else $error("accumulators not cleared after final pair");

    a_abs_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_abs_sum <= ABS_CAP && r_sq_sum <= SQ_CAP)
        else $error("accumulator above its saturation limit");

endmodule

// File: rtl/vdm_ctrl.sv
module vdm_ctrl
    import vdm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_last,
    input  t_sts i_sts,
    output logic o_ready,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_ACCUM: begin
                if (i_valid && i_last) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                n_state = S_ROOT;
            end
            S_ROOT: begin
                if (i_sts.root_done) begin
                    n_state = i_sts.out_free ? S_ACCUM : S_HOLD;
                end
            end
            S_HOLD: begin
                if (i_sts.out_free) begin
                    n_state = S_ACCUM;
                end
            end
            default: begin
                n_state = S_ACCUM;
            end
        endcase
    end

    always_comb begin
        o_ready          = 1'b0;
        o_cmd.start_root = 1'b0;
        o_cmd.load_out   = 1'b0;
        case (r_state)
            S_ACCUM: begin
                o_ready = 1'b1;
            end
            S_FINAL: begin
                o_cmd.start_root = 1'b1;
            end
            S_ROOT: begin
                o_cmd.load_out = i_sts.root_done && i_sts.out_free;
            end
            S_HOLD: begin
                o_cmd.load_out = i_sts.out_free;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACCUM;
        end else begin
            r_state <= n_state;
        end
    end

    a_final_to_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FINAL |=> r_state == S_ROOT)
        else $error("final pair not followed by the root");

    a_done_in_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.root_done |-> r_state == S_ROOT)
        else $error("root finished outside the root state");

    a_load_resumes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> r_state == S_ACCUM)
        else $error("result loaded but input not reopened");

endmodule

// File: rtl/vector_distance_metrics.sv
// Channel   Direction  Data                                         Marker
// s_axis    in         tdata[15:0] first_value, [31:16] second_value tlast = last_element
// m_axis    out        tdata[25:0] manhattan, [46:26] euclidean,     tuser = saturated
//                      [62:47] chebyshev, [63] zero
//
// A request on the input is taken every cycle while a vector streams in. After the
// request marked last, the input closes while the final state finishes the sums and starts
// the root, the bit-serial square root runs, and the result moves into the output
// register. The square root unit works out one root bit per cycle.
// Reset is synchronous and active low; it empties the sums and the output register.
// If the output is stalled, a finished result waits in the root unit and the input
// stays closed until the output register frees up.
module vector_distance_metrics
    import vdm_pkg::*;
#(
    parameter int unsigned MAX_LENGTH = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input pairs: [15:0] first_value, [31:16] second_value.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic                 s_axis_tlast,
    // Results: [25:0] manhattan_distance, [46:26] euclidean_distance,
    // [62:47] chebyshev_distance, [63] zero.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // Result flag: [0] saturated.
    output logic                 m_axis_tuser
);

    t_cmd              cmd;
    t_sts              sts;
    logic              ready;
    logic              accept;
    logic [ABS_W-1:0]  manhattan_distance;
    logic [ROOT_W-1:0] euclidean_distance;
    logic [DIFF_W-1:0] chebyshev_distance;
    logic              saturated;

    // A request is accepted when both sides of the handshake agree.
    assign accept        = s_axis_tvalid && ready;
    assign s_axis_tready = ready;

    vdm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_last  (s_axis_tlast),
        .i_sts   (sts),
        .o_ready (ready),
        .o_cmd   (cmd)
    );

    vdm_datapath #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_accept             (accept),
        .i_first_value        (s_axis_tdata[ELEM_W-1:0]),
        .i_second_value       (s_axis_tdata[2*ELEM_W-1:ELEM_W]),
        .i_last_element       (s_axis_tlast),
        .i_cmd                (cmd),
        .o_sts                (sts),
        .i_out_ready          (m_axis_tready),
        .o_out_valid          (m_axis_tvalid),
        .o_manhattan_distance (manhattan_distance),
        .o_euclidean_distance (euclidean_distance),
        .o_chebyshev_distance (chebyshev_distance),
        .o_saturated          (saturated)
    );

    // Pack the result fields from the lowest bit up, zero filled to 64 bits.
    assign m_axis_tdata = {1'b0, chebyshev_distance, euclidean_distance, manhattan_distance};
    assign m_axis_tuser = saturated;

    a_no_accept_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && s_axis_tlast) |=> !s_axis_tready)
        else $error("input still open after the final pair");

endmodule
